[src/tfd_pkg.sv]
// Shared types and constants for the telemetry frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfd_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 24;
    localparam int PROTO_POS   = 21;
    localparam int CHK_POS     = 22;
    localparam int TAIL_POS    = 23;

    // Held byte count, 0 to FRAME_BYTES
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_VALID = 3'd1,
        EV_TAIL  = 3'd2,
        EV_CHK   = 3'd3,
        EV_PROTO = 3'd4,
        EV_FLUSH = 3'd5
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD  = 2'd0,
        CFG_TAIL  = 2'd1,
        CFG_PROTO = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_CHECK = 2'd2
    } bk_state_t;

    // Queue entry handed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] protocol_byte;
    } cfg_t;

    // One result beat
    typedef struct packed {
        event_t             event_res;
        logic [31:0]        dropped_total;
        logic [7:0]         flags_byte;
        logic [7:0]         sequence_number;
        logic signed [31:0] hall_delta;
        logic signed [15:0] speed_milli;
        logic signed [15:0] steer_milli;
        logic signed [15:0] yaw_milli;
        logic [15:0]        battery_millivolts;
        logic [15:0]        interval_ms;
        logic [31:0]        status_word;
    } result_t;

endpackage

[src/tfd_cfg_regs.sv]
// Configuration register file: head, tail and protocol id bytes.
// Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tfd_pkg::cfg_t                   cfg
);
    import tfd_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // Address decode; unused index is ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                CFG_HEAD:  cfg_next.head_byte     = cfg_wdata;
                CFG_TAIL:  cfg_next.tail_byte     = cfg_wdata;
                CFG_PROTO: cfg_next.protocol_byte = cfg_wdata;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // A write to an unused index leaves every register alone
    a_unused_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wen && cfg_addr != CFG_HEAD && cfg_addr != CFG_TAIL && cfg_addr != CFG_PROTO)
        |=> $stable(cfg_reg))
        else $error("cfg write to unused index changed a register");

endmodule

[src/tfd_front.sv]
// Front end: accepts input beats, classifies them as data or flush and
// queues them for the back end. Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_front #(
    parameter int DEPTH = tfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  logic          s_flush,
    output logic          cmd_valid,
    output tfd_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import tfd_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_t               q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               push;
    cmd_t               cmd_in;

    // Classify: a flush carries no byte
    always_comb begin
        if (s_flush) begin
            cmd_in.kind = CMD_FLUSH;
            cmd_in.data = '0;
        end else begin
            cmd_in.kind = CMD_DATA;
            cmd_in.data = s_rx_byte;
        end
    end

    assign s_ready   = (fill_reg != FILL_W'(DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, cmd_pop})
            2'b10:   fill_next = fill_reg + FILL_W'(1);
            2'b01:   fill_next = fill_reg - FILL_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("back end popped an empty queue");

    a_fill_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !cmd_pop) |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("queue fill did not count a push");

endmodule

[src/tfd_back.sv]
// Back end: held byte window, head scan, frame checks, field unpack and
// the result register. Depends on tfd_pkg.
`timescale 1ns / 1ps

module tfd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tfd_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  tfd_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output tfd_pkg::result_t out_data
);
    import tfd_pkg::*;

    bk_state_t         state_reg, state_next;
    logic [7:0]        held_reg [FRAME_BYTES];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       dropped_reg, dropped_next;
    event_t            event_reg, event_next;
    logic              out_valid_reg;
    result_t           out_data_reg, result_next;

    logic [FRAME_BYTES-1:0] head_match;
    logic                   head_found;
    logic [CNT_W-1:0]       head_idx;
    logic [CNT_W-1:0]       shamt;
    logic [7:0]             shifted [FRAME_BYTES];
    logic                   shift_en, append_en, finish, out_free;
    logic [7:0]             xsum;
    logic                   tail_ok, chk_ok, proto_ok;

    assign out_free = !out_valid_reg || out_ready;

    // Head match over the held window, first match wins
    always_comb begin
        head_found = 1'b0;
        head_idx   = '0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            head_match[k] = (CNT_W'(k) < count_reg) && (held_reg[k] == cfg.head_byte);
        end
        for (int k = FRAME_BYTES - 1; k >= 0; k--) begin
            if (head_match[k]) begin
                head_found = 1'b1;
                head_idx   = CNT_W'(k);
            end
        end
    end

    // Drop-front shifter
    always_comb begin
        logic [CNT_W:0] src;
        src = '0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            src = (CNT_W + 1)'(k) + {1'b0, shamt};
            if (src < (CNT_W + 1)'(FRAME_BYTES)) begin
                shifted[k] = held_reg[src[CNT_W-1:0]];
            end else begin
                shifted[k] = held_reg[k];
            end
        end
    end

    // Frame checks on a full window
    always_comb begin
        xsum = '0;
        for (int k = 0; k < CHK_POS; k++) begin
            xsum = xsum ^ held_reg[k];
        end
    end

    assign tail_ok  = (held_reg[TAIL_POS] == cfg.tail_byte);
    assign chk_ok   = (held_reg[CHK_POS] == xsum);
    assign proto_ok = (held_reg[PROTO_POS] == cfg.protocol_byte);

    // Sequencer: next state, window updates and result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        event_next   = event_reg;
        cmd_pop      = 1'b0;
        shift_en     = 1'b0;
        shamt        = '0;
        append_en    = 1'b0;
        finish       = 1'b0;
        result_next  = '0;

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_FLUSH) begin
                        dropped_next = dropped_reg + 32'(count_reg);
                        count_next   = '0;
                        event_next   = EV_FLUSH;
                        finish       = 1'b1;
                    end else begin
                        append_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        event_next = EV_NONE;
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                if (!head_found) begin
                    // no head anywhere: everything held goes
                    dropped_next = dropped_reg + 32'(count_reg);
                    count_next   = '0;
                    finish       = 1'b1;
                    state_next   = BK_IDLE;
                end else begin
                    shift_en     = 1'b1;
                    shamt        = head_idx;
                    count_next   = count_reg - head_idx;
                    dropped_next = dropped_reg + 32'(head_idx);
                    if (head_idx == '0 && count_reg == CNT_W'(FRAME_BYTES)) begin
                        state_next = BK_CHECK;
                    end else begin
                        finish     = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_CHECK: begin
                if (!tail_ok || !chk_ok) begin
                    // drop the head byte and rescan the rest
                    event_next   = tail_ok ? EV_CHK : EV_TAIL;
                    shift_en     = 1'b1;
                    shamt        = CNT_W'(1);
                    count_next   = count_reg - CNT_W'(1);
                    dropped_next = dropped_reg + 32'd1;
                    state_next   = BK_SCAN;
                end else if (!proto_ok) begin
                    event_next   = EV_PROTO;
                    count_next   = '0;
                    dropped_next = dropped_reg + 32'(FRAME_BYTES);
                    finish       = 1'b1;
                    state_next   = BK_IDLE;
                end else begin
                    event_next                     = EV_VALID;
                    count_next                     = '0;
                    finish                         = 1'b1;
                    state_next                     = BK_IDLE;
                    result_next.flags_byte         = held_reg[1];
                    result_next.sequence_number    = held_reg[2];
                    result_next.hall_delta         = {held_reg[3], held_reg[4],
                                                      held_reg[5], held_reg[6]};
                    result_next.speed_milli        = {held_reg[7], held_reg[8]};
                    result_next.steer_milli        = {held_reg[9], held_reg[10]};
                    result_next.yaw_milli          = {held_reg[11], held_reg[12]};
                    result_next.battery_millivolts = {held_reg[13], held_reg[14]};
                    result_next.interval_ms        = {held_reg[15], held_reg[16]};
                    result_next.status_word        = {held_reg[17], held_reg[18],
                                                      held_reg[19], held_reg[20]};
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        result_next.event_res     = event_next;
        result_next.dropped_total = dropped_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            dropped_reg   <= '0;
            event_reg     <= EV_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            event_reg   <= event_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held window: append at the fill point or shift down
    always_ff @(posedge aclk) begin
        if (append_en) begin
            held_reg[count_reg] <= cmd.data;
        end else if (shift_en) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                held_reg[k] <= shifted[k];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (finish) begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAME_BYTES))
        else $error("held count beyond frame length");

    a_idle_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_IDLE |-> count_reg < CNT_W'(FRAME_BYTES))
        else $error("full window left between beats");

    a_check_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_CHECK |-> count_reg == CNT_W'(FRAME_BYTES))
        else $error("frame check on a partial window");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SCAN && !head_found) |=> out_valid_reg && state_reg == BK_IDLE)
        else $error("empty scan did not deliver a result");

endmodule

[src/telemetry_frame_deframer_top.sv]
// An ordinary byte is queued in the front end, popped by the back end sequencer in IDLE,
// scanned for a head in SCAN and, on a full window, checked in CHECK before its result is
// registered; a flush is queued, popped in IDLE and its result registered. A frame that fails
// tail or checksum drops its head byte and is rescanned. A new beat is popped only in IDLE.
// Reset (aresetn, synchronous, active low) clears registers, counts and the queue;
// held frame bytes are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module telemetry_frame_deframer_top #(
    parameter int QUEUE_DEPTH = tfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wen,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // byte input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    input  logic                           s_flush,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_event_res,
    output logic [31:0]                    m_dropped_total,
    output logic [7:0]                     m_flags_byte,
    output logic [7:0]                     m_sequence_number,
    output logic signed [31:0]             m_hall_delta,
    output logic signed [15:0]             m_speed_milli,
    output logic signed [15:0]             m_steer_milli,
    output logic signed [15:0]             m_yaw_milli,
    output logic [15:0]                    m_battery_millivolts,
    output logic [15:0]                    m_interval_ms,
    output logic [31:0]                    m_status_word
);
    import tfd_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t result;

    tfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .s_flush   (s_flush),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    // Unpack the result beat onto the ports
    assign m_event_res          = result.event_res;
    assign m_dropped_total      = result.dropped_total;
    assign m_flags_byte         = result.flags_byte;
    assign m_sequence_number    = result.sequence_number;
    assign m_hall_delta         = result.hall_delta;
    assign m_speed_milli        = result.speed_milli;
    assign m_steer_milli        = result.steer_milli;
    assign m_yaw_milli          = result.yaw_milli;
    assign m_battery_millivolts = result.battery_millivolts;
    assign m_interval_ms        = result.interval_ms;
    assign m_status_word        = result.status_word;

endmodule

[tb/sv/telemetry_frame_deframer_top_tb.sv]
// Testbench for telemetry_frame_deframer_top: drives bytes and flushes, predicts each
// result beat from its own deframer model and checks every field of every result.
// Depends on tfd_pkg (types, event codes, register indexes) and the top module.
`timescale 1ns / 1ps

module telemetry_frame_deframer_top_tb;

    import tfd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 200000;

    // Index past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        FR_GOOD,
        FR_BAD_TAIL,
        FR_BAD_CHK,
        FR_BAD_PROTO
    } frame_kind_t;

    // DUT signals; the inputs driven here are all known from time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = '0;
    logic                  s_flush   = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [2:0]            m_event_res;
    logic [31:0]           m_dropped_total;
    logic [7:0]            m_flags_byte;
    logic [7:0]            m_sequence_number;
    logic signed [31:0]    m_hall_delta;
    logic signed [15:0]    m_speed_milli;
    logic signed [15:0]    m_steer_milli;
    logic signed [15:0]    m_yaw_milli;
    logic [15:0]           m_battery_millivolts;
    logic [15:0]           m_interval_ms;
    logic [31:0]           m_status_word;

    // Deframer model state
    logic [7:0]  hold_mem [0:FRAME_BYTES-1];
    int unsigned held_n    = 0;
    logic [31:0] drop_cnt  = '0;
    logic [7:0]  cfg_head  = '0;
    logic [7:0]  cfg_tail  = '0;
    logic [7:0]  cfg_proto = '0;

    // Results predicted for accepted beats, oldest first
    result_t     results_due [$];

    // Frame under construction for the sender
    logic [7:0]  frame_buf [0:FRAME_BYTES-1];

    int          mismatch_count = 0;
    int          beats_sent     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_seq       = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;

    telemetry_frame_deframer_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wen              (cfg_wen),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .s_flush              (s_flush),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_event_res          (m_event_res),
        .m_dropped_total      (m_dropped_total),
        .m_flags_byte         (m_flags_byte),
        .m_sequence_number    (m_sequence_number),
        .m_hall_delta         (m_hall_delta),
        .m_speed_milli        (m_speed_milli),
        .m_steer_milli        (m_steer_milli),
        .m_yaw_milli          (m_yaw_milli),
        .m_battery_millivolts (m_battery_millivolts),
        .m_interval_ms        (m_interval_ms),
        .m_status_word        (m_status_word)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drop n bytes from the front of the held window
    function automatic void discard_front(int unsigned n);
        if (n >= held_n) begin
            drop_cnt += held_n;
            held_n = 0;
        end else begin
            for (int k = 0; k < held_n - n; k++) hold_mem[k] = hold_mem[k + n];
            held_n   -= n;
            drop_cnt += n;
        end
    endfunction

    // One byte or flush into the model; returns the result beat it causes
    function automatic result_t deframe_byte(logic [7:0] rx, logic fl);
        result_t     r;
        event_t      ev;
        int unsigned i;
        logic [7:0]  x;
        bit          done;
        r  = '0;
        ev = EV_NONE;
        if (fl) begin
            drop_cnt += held_n;
            held_n = 0;
            r.event_res     = EV_FLUSH;
            r.dropped_total = drop_cnt;
            return r;
        end
        if (held_n >= FRAME_BYTES) discard_front(1);
        hold_mem[held_n] = rx;
        held_n++;
        done = 1'b0;
        while (!done) begin
            i = 0;
            while (i < held_n && hold_mem[i] != cfg_head) i++;
            if (i == held_n) begin
                discard_front(held_n);
                done = 1'b1;
            end else begin
                if (i > 0) discard_front(i);
                if (held_n < FRAME_BYTES) begin
                    done = 1'b1;
                end else if (hold_mem[TAIL_POS] != cfg_tail) begin
                    ev = EV_TAIL;
                    discard_front(1);
                end else begin
                    x = '0;
                    for (int k = 0; k < CHK_POS; k++) x ^= hold_mem[k];
                    if (hold_mem[CHK_POS] != x) begin
                        ev = EV_CHK;
                        discard_front(1);
                    end else if (hold_mem[PROTO_POS] != cfg_proto) begin
                        ev = EV_PROTO;
                        discard_front(FRAME_BYTES);
                    end else begin
                        // good frame: unpack big-endian, window consumed
                        ev = EV_VALID;
                        r.flags_byte         = hold_mem[1];
                        r.sequence_number    = hold_mem[2];
                        r.hall_delta         = {hold_mem[3], hold_mem[4], hold_mem[5],
                                                hold_mem[6]};
                        r.speed_milli        = {hold_mem[7], hold_mem[8]};
                        r.steer_milli        = {hold_mem[9], hold_mem[10]};
                        r.yaw_milli          = {hold_mem[11], hold_mem[12]};
                        r.battery_millivolts = {hold_mem[13], hold_mem[14]};
                        r.interval_ms        = {hold_mem[15], hold_mem[16]};
                        r.status_word        = {hold_mem[17], hold_mem[18], hold_mem[19],
                                                hold_mem[20]};
                        held_n = 0;
                    end
                end
            end
        end
        r.event_res     = ev;
        r.dropped_total = drop_cnt;
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every accepted beat against the oldest prediction
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result beat with no prediction pending: event_res %0d",
                       m_event_res);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (m_event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, m_event_res);
                    mismatch_count++;
                end
                if (m_dropped_total !== want.dropped_total) begin
                    $error("dropped_total: expected %0d, got %0d",
                           want.dropped_total, m_dropped_total);
                    mismatch_count++;
                end
                if (m_flags_byte !== want.flags_byte) begin
                    $error("flags_byte: expected %h, got %h", want.flags_byte, m_flags_byte);
                    mismatch_count++;
                end
                if (m_sequence_number !== want.sequence_number) begin
                    $error("sequence_number: expected %0d, got %0d",
                           want.sequence_number, m_sequence_number);
                    mismatch_count++;
                end
                if (m_hall_delta !== want.hall_delta) begin
                    $error("hall_delta: expected %0d, got %0d", want.hall_delta, m_hall_delta);
                    mismatch_count++;
                end
                if (m_speed_milli !== want.speed_milli) begin
                    $error("speed_milli: expected %0d, got %0d",
                           want.speed_milli, m_speed_milli);
                    mismatch_count++;
                end
                if (m_steer_milli !== want.steer_milli) begin
                    $error("steer_milli: expected %0d, got %0d",
                           want.steer_milli, m_steer_milli);
                    mismatch_count++;
                end
                if (m_yaw_milli !== want.yaw_milli) begin
                    $error("yaw_milli: expected %0d, got %0d", want.yaw_milli, m_yaw_milli);
                    mismatch_count++;
                end
                if (m_battery_millivolts !== want.battery_millivolts) begin
                    $error("battery_millivolts: expected %0d, got %0d",
                           want.battery_millivolts, m_battery_millivolts);
                    mismatch_count++;
                end
                if (m_interval_ms !== want.interval_ms) begin
                    $error("interval_ms: expected %0d, got %0d",
                           want.interval_ms, m_interval_ms);
                    mismatch_count++;
                end
                if (m_status_word !== want.status_word) begin
                    $error("status_word: expected %h, got %h", want.status_word, m_status_word);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one beat and wait for it to be taken; valid is left high
    task automatic send_beat(input logic [7:0] rx, input logic fl);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        s_flush   <= fl;
        do @(posedge aclk); while (!s_ready);
        results_due.insert(results_due.size(), deframe_byte(rx, fl));
        beats_sent++;
    endtask

    task automatic send_frame_buf(input int n);
        for (int k = 0; k < n; k++) send_beat(frame_buf[k], 1'b0);
    endtask

    // Checksum over bytes 0..21 into byte 22
    function automatic void seal_frame();
        logic [7:0] x;
        x = '0;
        for (int k = 0; k < CHK_POS; k++) x ^= frame_buf[k];
        frame_buf[CHK_POS] = x;
    endfunction

    // Random frame for the current registers, optionally broken one way
    function automatic void build_frame(frame_kind_t kind);
        frame_buf[0] = cfg_head;
        for (int k = 1; k < PROTO_POS; k++)
            frame_buf[k] = ($urandom_range(9) == 0) ? cfg_head : 8'($urandom);
        frame_buf[PROTO_POS] = cfg_proto;
        frame_buf[TAIL_POS]  = cfg_tail;
        if (kind == FR_BAD_PROTO) frame_buf[PROTO_POS] ^= 8'($urandom_range(255, 1));
        seal_frame();
        if (kind == FR_BAD_CHK)  frame_buf[CHK_POS]  ^= 8'($urandom_range(255, 1));
        if (kind == FR_BAD_TAIL) frame_buf[TAIL_POS] ^= 8'($urandom_range(255, 1));
    endfunction

    // Stop offering, wait for all results, then let the block go quiet
    task automatic drain_and_settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; the model follows at once since the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_HEAD:  cfg_head  = val;
            CFG_TAIL:  cfg_tail  = val;
            CFG_PROTO: cfg_proto = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] h, input logic [7:0] t, input logic [7:0] p);
        write_reg(CFG_HEAD, h);
        write_reg(CFG_TAIL, t);
        write_reg(CFG_PROTO, p);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Reset registers (all zero): flush when empty, stray byte, frame with extreme fields
    task automatic test_reset_defaults();
        send_beat(8'hA7, 1'b1);
        send_beat(8'h55, 1'b0);
        frame_buf[0]  = cfg_head;
        frame_buf[1]  = 8'hFF;
        frame_buf[2]  = 8'h00;
        frame_buf[3]  = 8'h80;
        frame_buf[4]  = 8'h00;
        frame_buf[5]  = 8'h00;
        frame_buf[6]  = 8'h00;
        frame_buf[7]  = 8'h7F;
        frame_buf[8]  = 8'hFF;
        frame_buf[9]  = 8'h80;
        frame_buf[10] = 8'h00;
        frame_buf[11] = 8'hFF;
        frame_buf[12] = 8'hFF;
        frame_buf[13] = 8'hFF;
        frame_buf[14] = 8'hFF;
        frame_buf[15] = 8'h00;
        frame_buf[16] = 8'h00;
        for (int k = 17; k < PROTO_POS; k++) frame_buf[k] = 8'hFF;
        frame_buf[PROTO_POS] = cfg_proto;
        frame_buf[TAIL_POS]  = cfg_tail;
        seal_frame();
        send_frame_buf(FRAME_BYTES);
        drain_and_settle();
    endtask

    // Bytes held under one head value, then the head changes before the next byte
    task automatic test_rescan_on_new_head();
        set_config(8'hA5, 8'h5A, 8'h01);
        build_frame(FR_GOOD);
        frame_buf[5] = 8'h3C;
        send_frame_buf(12);
        drain_and_settle();
        write_reg(CFG_HEAD, 8'h3C);
        write_reg(CFG_UNUSED, 8'hA5);
        build_frame(FR_GOOD);
        send_frame_buf(FRAME_BYTES);
        drain_and_settle();
    endtask

    // Mostly well-formed frames with random content, the rest errors, noise and flushes
    task automatic test_random_traffic(input int n_beats);
        int start;
        int pick;
        int len;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                build_frame(FR_GOOD);
                send_frame_buf(FRAME_BYTES);
            end else if (pick < 65) begin
                build_frame(FR_BAD_TAIL);
                send_frame_buf(FRAME_BYTES);
            end else if (pick < 75) begin
                build_frame(FR_BAD_CHK);
                send_frame_buf(FRAME_BYTES);
            end else if (pick < 83) begin
                build_frame(FR_BAD_PROTO);
                send_frame_buf(FRAME_BYTES);
            end else if (pick < 90) begin
                len = $urandom_range(6, 1);
                repeat (len) send_beat(8'($urandom), 1'b0);
            end else if (pick < 96) begin
                // cut-off frame, often followed by a flush
                build_frame(FR_GOOD);
                send_frame_buf($urandom_range(FRAME_BYTES - 1, 1));
                if ($urandom_range(1)) send_beat(8'($urandom), 1'b1);
            end else begin
                send_beat(8'($urandom), 1'b1);
            end
        end
        drain_and_settle();
    endtask

    // Receiver stops for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_seq++;
        build_frame(FR_GOOD);
        send_frame_buf(FRAME_BYTES);
        build_frame(FR_BAD_CHK);
        send_frame_buf(FRAME_BYTES);
        repeat (16) send_beat(8'($urandom), 1'b0);
        drain_and_settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // sender rarely idle, receiver mostly stalled
        set_idling(17, 88);
        test_reset_defaults();
        test_rescan_on_new_head();
        set_config(8'h7E, 8'h81, 8'h01);
        test_random_traffic(260);

        // sender mostly idle, receiver rarely stalled; extreme register values
        set_idling(88, 17);
        set_config(8'h00, 8'hFF, 8'hFF);
        test_random_traffic(260);

        // no idling either side
        set_idling(0, 0);
        set_config(8'hFF, 8'h00, 8'h00);
        test_backpressure();
        test_random_traffic(120);
        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        write_reg(CFG_UNUSED, 8'($urandom));
        test_random_traffic(120);

        drain_and_settle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
